[rtl/drpah_pkg.sv]
// Shared types, constants and helpers of the diagonal region pixel adjust block.
package drpah_pkg;

    localparam int X_W      = 12;
    localparam int DIM_W    = 13;
    localparam int CHAN_W   = 8;
    localparam int GAIN_W   = 10;
    localparam int OFS_W    = 9;
    localparam int COUNT_W  = 25;
    localparam int NUM_BINS = 8;
    localparam int BIN_W    = 3;
    localparam int REGION_W = 2;
    localparam int GREY_W   = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam longint unsigned MAX_DIM         = 64'd4096;
    localparam longint unsigned COUNT_FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned DIM_SQ          = MAX_DIM * MAX_DIM;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT  =
        (DIM_SQ > COUNT_FIELD_MAX) ? COUNT_W'(COUNT_FIELD_MAX) : COUNT_W'(DIM_SQ);

    // grey = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
    localparam logic [9:0] GREY_RECIP = 10'd683;
    localparam int         GREY_SHIFT = 11;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd512;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd512;
    localparam logic [GAIN_W-1:0] RST_GAIN   = 10'd320;
    localparam logic [OFS_W-1:0]  RST_OFFSET = 9'd50;

    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IDX_GAIN   = 2'd2;
    localparam logic [1:0] CFG_IDX_OFFSET = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    localparam logic [REGION_W-1:0] REGION_RED_MINUS_GREY = 2'd0;
    localparam logic [REGION_W-1:0] REGION_BRIGHTEN       = 2'd1;
    localparam logic [REGION_W-1:0] REGION_PASS           = 2'd2;
    localparam logic [REGION_W-1:0] REGION_SCALE          = 2'd3;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef struct packed {
        logic [X_W-1:0]    x_pos;
        logic [X_W-1:0]    y_pos;
        logic [CHAN_W-1:0] chan_blue;
        logic [CHAN_W-1:0] chan_green;
        logic [CHAN_W-1:0] chan_red;
        logic              frame_end;
    } t_in_item;

    typedef struct packed {
        logic                item_kind;
        logic [CHAN_W-1:0]   out_blue;
        logic [CHAN_W-1:0]   out_green;
        logic [CHAN_W-1:0]   out_red;
        logic [REGION_W-1:0] region_id;
        logic [BIN_W-1:0]    bin_number;
        logic [COUNT_W-1:0]  bin_count;
        logic                last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0]         image_width;
        logic [DIM_W-1:0]         image_height;
        logic [GAIN_W-1:0]        gain_q8;
        logic signed [OFS_W-1:0]  brightness_offset;
    } t_cfg;

    // one item in the read-modify-write stage: a pixel or a bin report
    typedef struct packed {
        logic              kind;
        logic [X_W-1:0]    x_pos;
        logic [X_W-1:0]    y_pos;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_end;
        logic [GREY_W-1:0] grey;
        logic [BIN_W-1:0]  bin;
    } t_stage;

    typedef struct packed {
        logic               rd_en;
        logic [BIN_W-1:0]   rd_addr;
        logic               wr_en;
        logic [BIN_W-1:0]   wr_addr;
        logic [COUNT_W-1:0] wr_data;
    } t_hist_req;

    function automatic logic [GREY_W-1:0] grey_of(input logic [CHAN_W-1:0] b,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] r);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(b) + 10'(g) + 10'(r);
        prod = 20'(sum) * 20'(GREY_RECIP);
        return prod[GREY_SHIFT +: GREY_W];
    endfunction

endpackage

[rtl/diagonal_region_pixel_adjust_histogram.sv]
// Top level: input stage, histogram read-modify-write sequencing, output register.
// Path: a pixel passes the input stage, drpah_pix and output registers before o_out_valid.
// Throughput: one pixel per cycle while i_out_stall is low and no bin report runs.
// A frame_end pixel is followed by 8 bin reports, one per cycle while not stalled, read and zeroed
// through the RAM port; input requests stall until the last bin report enters the input stage.
// Reset (synchronous, active low) loads the register defaults and marks all bins empty.
module diagonal_region_pixel_adjust_histogram #(
    parameter longint unsigned MAX_DIM = drpah_pkg::MAX_DIM
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  drpah_pkg::t_in_item                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output drpah_pkg::t_out_item               o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drpah_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [drpah_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [drpah_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam longint unsigned DIM_SQ = MAX_DIM * MAX_DIM;
    localparam logic [drpah_pkg::COUNT_W-1:0] COUNT_LIMIT =
        (DIM_SQ > drpah_pkg::COUNT_FIELD_MAX) ?
            drpah_pkg::COUNT_W'(drpah_pkg::COUNT_FIELD_MAX) : drpah_pkg::COUNT_W'(DIM_SQ);

    drpah_pkg::t_cfg       cfg;
    drpah_pkg::t_hist_req  hist_req;
    logic [drpah_pkg::COUNT_W-1:0] hist_count;

    logic                  r_s1_vld, n_s1_vld;
    drpah_pkg::t_stage     r_s1, n_s1;
    logic                  r_out_vld, n_out_vld;
    drpah_pkg::t_out_item  r_out, n_out;

    logic                  s2_vld;
    drpah_pkg::t_out_item  s2_res;

    logic                  adv, rep_next, in_acc, inject;
    logic [drpah_pkg::GREY_W-1:0] in_grey;
    logic [drpah_pkg::BIN_W-1:0]  rep_idx;

    drpah_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    drpah_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hist_req),
        .o_count (hist_count)
    );

    drpah_pix u_pix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_s1_vld (r_s1_vld),
        .i_s1     (r_s1),
        .i_count  (hist_count),
        .i_cfg    (cfg),
        .o_vld    (s2_vld),
        .o_res    (s2_res)
    );

    assign adv = !r_out_vld || !i_out_stall;

    // a report sequence follows a frame_end pixel and runs until the last bin
    assign rep_next = r_s1_vld &&
        (((r_s1.kind == drpah_pkg::KIND_PIXEL) && r_s1.frame_end) ||
         ((r_s1.kind == drpah_pkg::KIND_BIN) && (r_s1.bin != drpah_pkg::LAST_BIN)));

    assign o_in_stall = !adv || rep_next;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign inject     = adv && rep_next;
    assign rep_idx    = (r_s1.kind == drpah_pkg::KIND_PIXEL) ? '0
                                                             : r_s1.bin + drpah_pkg::BIN_W'(1);
    assign in_grey    = drpah_pkg::grey_of(i_in_data.chan_blue, i_in_data.chan_green,
                                           i_in_data.chan_red);

    always_comb begin
        n_s1     = r_s1;
        n_s1_vld = r_s1_vld;
        if (adv) begin
            n_s1_vld = inject || in_acc;
            if (inject) begin
                n_s1      = '0;
                n_s1.kind = drpah_pkg::KIND_BIN;
                n_s1.bin  = rep_idx;
            end else begin
                n_s1.kind      = drpah_pkg::KIND_PIXEL;
                n_s1.x_pos     = i_in_data.x_pos;
                n_s1.y_pos     = i_in_data.y_pos;
                n_s1.blue      = i_in_data.chan_blue;
                n_s1.green     = i_in_data.chan_green;
                n_s1.red       = i_in_data.chan_red;
                n_s1.frame_end = i_in_data.frame_end;
                n_s1.grey      = in_grey;
                n_s1.bin       = in_grey[drpah_pkg::GREY_W-1 -: drpah_pkg::BIN_W];
            end
        end
    end

    // count the pixel with saturation, or zero the bin being reported
    always_comb begin
        hist_req.rd_en   = inject || in_acc;
        hist_req.rd_addr = n_s1.bin;
        hist_req.wr_en   = adv && r_s1_vld;
        hist_req.wr_addr = r_s1.bin;
        if (r_s1.kind == drpah_pkg::KIND_BIN) begin
            hist_req.wr_data = '0;
        end else if (hist_count < COUNT_LIMIT) begin
            hist_req.wr_data = hist_count + drpah_pkg::COUNT_W'(1);
        end else begin
            hist_req.wr_data = hist_count;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (adv) begin
            n_out_vld = s2_vld;
            n_out     = s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_bins_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_stall && (r_out.item_kind == drpah_pkg::KIND_BIN) &&
         (r_out.bin_number != drpah_pkg::LAST_BIN))
        |=> (r_out_vld && (r_out.item_kind == drpah_pkg::KIND_BIN) &&
             (r_out.bin_number == drpah_pkg::BIN_W'($past(r_out.bin_number) + 1))))
        else $error("bin reports not delivered in order");

    a_stall_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && (r_s1.kind == drpah_pkg::KIND_BIN) &&
         (r_s1.bin != drpah_pkg::LAST_BIN)) |-> o_in_stall)
        else $error("pixel request taken during a bin report");

    a_pixel_after_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_vld && (r_s1.kind == drpah_pkg::KIND_PIXEL) && r_s1.frame_end)
        |=> (r_s1_vld && (r_s1.kind == drpah_pkg::KIND_BIN) && (r_s1.bin == '0)))
        else $error("report did not start with bin zero");

endmodule

[rtl/drpah_cfg.sv]
// APB register file for frame size, gain and brightness offset.
module drpah_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drpah_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [drpah_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [drpah_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output drpah_pkg::t_cfg                    o_cfg
);

    drpah_pkg::t_cfg r_cfg;
    logic [1:0]      reg_idx;
    logic            wr_hit;

    assign reg_idx = paddr[drpah_pkg::APB_ADDR_W-1:2];
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width       <= drpah_pkg::RST_WIDTH;
            r_cfg.image_height      <= drpah_pkg::RST_HEIGHT;
            r_cfg.gain_q8           <= drpah_pkg::RST_GAIN;
            r_cfg.brightness_offset <= drpah_pkg::RST_OFFSET;
        end else if (wr_hit) begin
            case (reg_idx)
                drpah_pkg::CFG_IDX_WIDTH: begin
                    r_cfg.image_width <= pwdata[drpah_pkg::DIM_W-1:0];
                end
                drpah_pkg::CFG_IDX_HEIGHT: begin
                    r_cfg.image_height <= pwdata[drpah_pkg::DIM_W-1:0];
                end
                drpah_pkg::CFG_IDX_GAIN: begin
                    r_cfg.gain_q8 <= pwdata[drpah_pkg::GAIN_W-1:0];
                end
                drpah_pkg::CFG_IDX_OFFSET: begin
                    r_cfg.brightness_offset <= pwdata[drpah_pkg::OFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            drpah_pkg::CFG_IDX_WIDTH:  prdata = drpah_pkg::APB_DATA_W'(r_cfg.image_width);
            drpah_pkg::CFG_IDX_HEIGHT: prdata = drpah_pkg::APB_DATA_W'(r_cfg.image_height);
            drpah_pkg::CFG_IDX_GAIN:   prdata = drpah_pkg::APB_DATA_W'(r_cfg.gain_q8);
            drpah_pkg::CFG_IDX_OFFSET: begin
                prdata = drpah_pkg::APB_DATA_W'(unsigned'(r_cfg.brightness_offset));
            end
            default: prdata = '0;
        endcase
    end

endmodule

[rtl/drpah_hist.sv]
// Histogram RAM: one read and one write port, registered read, write-to-read forwarding.
module drpah_hist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  drpah_pkg::t_hist_req                i_req,
    output logic [drpah_pkg::COUNT_W-1:0]       o_count
);

    logic [drpah_pkg::COUNT_W-1:0]  mem [drpah_pkg::NUM_BINS];
    logic [drpah_pkg::NUM_BINS-1:0] r_written;
    logic [drpah_pkg::COUNT_W-1:0]  r_rd_mem;
    logic [drpah_pkg::COUNT_W-1:0]  r_fwd_data;
    logic                           r_fwd;
    logic                           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_mem   <= mem[i_req.rd_addr];
            r_fwd_data <= i_req.wr_data;
        end
    end

    // bins never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_fwd     <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_fwd    <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
                r_rd_vld <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_count = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_mem : '0);

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.rd_en && i_req.wr_en && (i_req.wr_addr == i_req.rd_addr))
        |=> (o_count == $past(i_req.wr_data)))
        else $error("histogram read missed a same-cycle write");

endmodule

[rtl/drpah_pix.sv]
// Pixel datapath: diagonal products and channel gains, then region select and clamping; bin reports carry their count.
module drpah_pix (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_s1_vld,
    input  drpah_pkg::t_stage               i_s1,
    input  logic [drpah_pkg::COUNT_W-1:0]   i_count,
    input  drpah_pkg::t_cfg                 i_cfg,
    output logic                            o_vld,
    output drpah_pkg::t_out_item            o_res
);

    localparam int PROD_W  = 25;
    localparam int SPROD_W = 28;
    localparam int SCALE_W = drpah_pkg::CHAN_W + drpah_pkg::GAIN_W;

    logic [PROD_W-1:0]         yw, hx;
    logic signed [13:0]        dwx;
    logic signed [SPROD_W-1:0] h_s, d_s, hwx;
    logic [SCALE_W-1:0]        sc_b, sc_g, sc_r;

    logic                      r_vld;
    logic [PROD_W-1:0]         r_yw, r_hx;
    logic signed [SPROD_W-1:0] r_hwx;
    logic [SCALE_W-1:0]        r_sc_b, r_sc_g, r_sc_r;
    drpah_pkg::t_stage         r_s2;
    logic [drpah_pkg::COUNT_W-1:0] r_count;

    logic first_diag, second_diag;

    function automatic logic [drpah_pkg::CHAN_W-1:0] sat_scale(input logic [SCALE_W-1:0] p);
        logic [drpah_pkg::CHAN_W-1:0] v;
        if (p[SCALE_W-1:16] != '0) begin
            v = 8'd255;
        end else begin
            v = p[15:8];
        end
        return v;
    endfunction

    function automatic logic [drpah_pkg::CHAN_W-1:0] add_clamp(
        input logic [drpah_pkg::CHAN_W-1:0]       c,
        input logic signed [drpah_pkg::OFS_W-1:0] ofs
    );
        logic signed [10:0]           s;
        logic [drpah_pkg::CHAN_W-1:0] v;
        s = signed'(11'(c)) + 11'(ofs);
        if (s < 0) begin
            v = '0;
        end else if (s > 11'sd255) begin
            v = 8'd255;
        end else begin
            v = s[7:0];
        end
        return v;
    endfunction

    always_comb begin
        yw   = PROD_W'(i_s1.y_pos) * PROD_W'(i_cfg.image_width);
        hx   = PROD_W'(i_s1.x_pos) * PROD_W'(i_cfg.image_height);
        dwx  = signed'({1'b0, i_cfg.image_width}) - signed'({2'b0, i_s1.x_pos});
        h_s  = SPROD_W'(signed'({1'b0, i_cfg.image_height}));
        d_s  = SPROD_W'(dwx);
        hwx  = h_s * d_s;
        sc_b = SCALE_W'(i_s1.blue)  * SCALE_W'(i_cfg.gain_q8);
        sc_g = SCALE_W'(i_s1.green) * SCALE_W'(i_cfg.gain_q8);
        sc_r = SCALE_W'(i_s1.red)   * SCALE_W'(i_cfg.gain_q8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_yw    <= yw;
            r_hx    <= hx;
            r_hwx   <= hwx;
            r_sc_b  <= sc_b;
            r_sc_g  <= sc_g;
            r_sc_r  <= sc_r;
            r_s2    <= i_s1;
            r_count <= i_count;
        end
    end

    assign first_diag  = r_yw > r_hx;
    assign second_diag = signed'(SPROD_W'(r_yw)) > r_hwx;

    always_comb begin
        o_res = '0;
        if (r_s2.kind == drpah_pkg::KIND_BIN) begin
            o_res.item_kind   = drpah_pkg::KIND_BIN;
            o_res.bin_number  = r_s2.bin;
            o_res.bin_count   = r_count;
            o_res.last_of_run = (r_s2.bin == drpah_pkg::LAST_BIN);
        end else begin
            o_res.item_kind   = drpah_pkg::KIND_PIXEL;
            o_res.last_of_run = !r_s2.frame_end;
            if (first_diag && !second_diag) begin
                o_res.region_id = drpah_pkg::REGION_RED_MINUS_GREY;
                o_res.out_blue  = (r_s2.red > r_s2.grey) ? (r_s2.red - r_s2.grey) : '0;
                o_res.out_green = o_res.out_blue;
                o_res.out_red   = o_res.out_blue;
            end else if (first_diag) begin
                o_res.region_id = drpah_pkg::REGION_BRIGHTEN;
                o_res.out_blue  = add_clamp(r_s2.blue,  i_cfg.brightness_offset);
                o_res.out_green = add_clamp(r_s2.green, i_cfg.brightness_offset);
                o_res.out_red   = add_clamp(r_s2.red,   i_cfg.brightness_offset);
            end else if (second_diag) begin
                o_res.region_id = drpah_pkg::REGION_PASS;
                o_res.out_blue  = r_s2.blue;
                o_res.out_green = r_s2.green;
                o_res.out_red   = r_s2.red;
            end else begin
                o_res.region_id = drpah_pkg::REGION_SCALE;
                o_res.out_blue  = sat_scale(r_sc_b);
                o_res.out_green = sat_scale(r_sc_g);
                o_res.out_red   = sat_scale(r_sc_r);
            end
        end
    end

    assign o_vld = r_vld;

endmodule
